// ===== design/mtg_pkg.sv =====
// ============================================================================
// mtg_pkg
// Shared constants, controller types and the tempering function of the
// MT19937 generator.
// ============================================================================
`default_nettype none

package mtg_pkg;

    localparam int unsigned STATE_DEPTH_DEF  = 624;
    localparam int unsigned SHIFT_OFFSET_DEF = 397;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned S_TDATA_W = 8;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_TWIST
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic seed_start;  // load seed into word 0, restart counters
        logic seed_mul;    // multiply step of the seed recurrence
        logic seed_add;    // add index, write word k
        logic draw_rd;     // read next and far words for the current position
        logic draw_wr;     // twist current word, write back, load output
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic seeded;      // store holds a valid seeding
        logic seed_last;   // seed counter sits on the last word
        logic out_full;    // output register occupied and not taken this cycle
    } t_ctl_sts;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== design/mersenne_twister_generator.sv =====
// ============================================================================
// mersenne_twister_generator
// 32-bit MT19937 pseudo-random word generator with streaming request and
// result channels.
// ============================================================================
// Usage:
//   Each transaction on the slave channel is one request; bit 0 of
//   i_s_tdata is the reseed flag. Each request yields exactly one tempered
//   32-bit word as a transaction on the master channel.
//   The seed register is written through i_cfg_wr_en / i_cfg_wr_data and is
//   used at the next seeding only; it resets to 5489.
// Timing:
//   A plain draw reads the neighbor and far words from the two read ports
//   of the state RAM in the accepting cycle, then twists, writes back and
//   tempers once the output register is free. The result is valid the
//   cycle after the twist. A request with reseed set, or the first request
//   after reset, first runs the seed recurrence after the accepting cycle
//   (multiply, then add and write, per word, through the single 32x32
//   multiplier). The draw's read overlaps the last add.
// Reset and stall:
//   Reset leaves the store unseeded and the output register empty. A result
//   waiting in the output register does not block the next request; that
//   request's twist holds until the register is free.
// ============================================================================
`default_nettype none

module mersenne_twister_generator
    import mtg_pkg::*;
#(
    parameter int unsigned STATE_DEPTH  = STATE_DEPTH_DEF,
    parameter int unsigned SHIFT_OFFSET = SHIFT_OFFSET_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,     // [0] reseed, [7:1] zero
    // result channel
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [WORD_W-1:0]    o_m_tdata,     // [31:0] random_word
    // seed register
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [WORD_W-1:0]    i_cfg_wr_data
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    // sequencer: accepts requests, steps seeding and the per-word twist
    mtg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_reseed   (i_s_tdata[0]),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // store, arithmetic and output register
    mtg_datapath #(
        .STATE_DEPTH  (STATE_DEPTH),
        .SHIFT_OFFSET (SHIFT_OFFSET)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== design/mtg_ram.sv =====
// ============================================================================
// mtg_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
`default_nettype none

module mtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== design/mtg_ctrl.sv =====
// ============================================================================
// mtg_ctrl
// Sequencer for seeding and per-word twist of the MT19937 generator.
// ============================================================================
`default_nettype none

module mtg_ctrl
    import mtg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    input  wire logic     i_reseed,
    output logic          o_s_tready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_need_seed;

    assign w_accept    = i_s_tvalid && (r_state == ST_IDLE);
    assign w_need_seed = i_reseed || !i_sts.seeded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_seed ? ST_SEED_MUL : ST_TWIST;
                end
            end
            ST_SEED_MUL: begin
                n_state = ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
                n_state = i_sts.seed_last ? ST_TWIST : ST_SEED_MUL;
            end
            ST_TWIST: begin
                if (!i_sts.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready       = 1'b1;
                o_cmd.seed_start = w_accept && w_need_seed;
                o_cmd.draw_rd    = w_accept && !w_need_seed;
            end
            ST_SEED_MUL: begin
                o_cmd.seed_mul = 1'b1;
            end
            ST_SEED_ADD: begin
                o_cmd.seed_add = 1'b1;
                o_cmd.draw_rd  = i_sts.seed_last;
            end
            ST_TWIST: begin
                o_cmd.draw_wr = !i_sts.out_full;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mtg_datapath.sv =====
// ============================================================================
// mtg_datapath
// State store, seed recurrence, per-word twist, tempering and output register.
// ============================================================================
`default_nettype none

module mtg_datapath
    import mtg_pkg::*;
#(
    parameter int unsigned STATE_DEPTH  = STATE_DEPTH_DEF,
    parameter int unsigned SHIFT_OFFSET = SHIFT_OFFSET_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [WORD_W-1:0] i_cfg_wr_data,
    input  wire t_ctl_cmd          i_cmd,
    output t_ctl_sts               o_sts,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    output logic      [WORD_W-1:0] o_m_tdata
);

    localparam int unsigned ADDR_W = $clog2(STATE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STATE_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_EXT  = (ADDR_W+1)'(STATE_DEPTH);
    localparam logic [ADDR_W:0]   OFFSET_EXT = (ADDR_W+1)'(SHIFT_OFFSET);

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_p;
    logic [WORD_W-1:0] r_prod;
    logic [ADDR_W-1:0] r_k;
    logic [ADDR_W-1:0] r_pos;
    logic [WORD_W-1:0] r_cur;
    logic              r_seeded;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;

    logic [ADDR_W-1:0] n_nxt_addr;
    logic [ADDR_W:0]   w_far_sum;
    logic [ADDR_W-1:0] n_far_addr;
    logic [WORD_W-1:0] w_rd_nxt;
    logic [WORD_W-1:0] w_rd_far;
    logic [WORD_W-1:0] w_y;
    logic [WORD_W-1:0] n_twisted;
    logic [WORD_W-1:0] n_seed_word;
    logic [WORD_W-1:0] w_mix;

    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;

    // neighbor and far addresses, wrapped around the store
    assign n_nxt_addr = (r_pos == LAST_ADDR) ? '0 : r_pos + 1'b1;
    assign w_far_sum  = {1'b0, r_pos} + OFFSET_EXT;
    assign n_far_addr = (w_far_sum >= DEPTH_EXT) ? ADDR_W'(w_far_sum - DEPTH_EXT)
                                                 : ADDR_W'(w_far_sum);

    assign w_y       = (r_cur & HIGH_BIT) | (w_rd_nxt & LOW_BITS);
    assign n_twisted = w_rd_far ^ (w_y >> 1) ^ (w_y[0] ? TWIST_MATRIX : '0);

    assign w_mix       = r_p ^ (r_p >> 30);
    assign n_seed_word = r_prod + WORD_W'(r_k);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = n_twisted;
        priority if (i_cmd.seed_start) begin
            w_wr_en   = 1'b1;
            w_wr_addr = '0;
            w_wr_data = r_seed;
        end else if (i_cmd.seed_add) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_k;
            w_wr_data = n_seed_word;
        end else if (i_cmd.draw_wr) begin
            w_wr_en   = 1'b1;
        end else begin
            w_wr_en   = 1'b0;
        end
    end

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_en     (i_cmd.draw_rd),
        .i_rd_addr_a (n_nxt_addr),
        .i_rd_addr_b (n_far_addr),
        .o_rd_data_a (w_rd_nxt),
        .o_rd_data_b (w_rd_far)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_seeded    <= 1'b0;
            r_pos       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            if (i_cmd.seed_start) begin
                r_seeded <= 1'b1;
                r_pos    <= '0;
                r_k      <= ADDR_W'(1);
            end else if (i_cmd.seed_add) begin
                r_k <= r_k + 1'b1;
            end else if (i_cmd.draw_wr) begin
                r_pos <= n_nxt_addr;
            end
            if (i_cmd.draw_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_p   <= r_seed;
            r_cur <= r_seed;
        end else if (i_cmd.seed_add) begin
            r_p <= n_seed_word;
        end else if (i_cmd.draw_wr) begin
            r_cur <= w_rd_nxt;
        end
        if (i_cmd.seed_mul) begin
            r_prod <= SEED_MULT * w_mix;
        end
        if (i_cmd.draw_wr) begin
            r_out_data <= temper(n_twisted);
        end
    end

    assign o_sts.seeded    = r_seeded;
    assign o_sts.seed_last = (r_k == LAST_ADDR);
    assign o_sts.out_full  = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== design/mtg_checker.sv =====
// ============================================================================
// mtg_checker
// Port-level checks of the MT19937 generator, bound to the top level.
// ============================================================================
`default_nettype none

module mtg_checker
    import mtg_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [WORD_W-1:0]    o_m_tdata
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pend;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    // result only for an outstanding request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_pend != 2'd0))
        else $error("result without outstanding request");

    // one request in work plus one waiting result at most
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many outstanding requests");

    // a request is never followed at once by another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_tready)
        else $error("request accepted in back-to-back cycles");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
